// ----- hw/rtl/binary_lifting_lca_assert.svh -----
// assertion macros for the lowest common ancestor engine
`ifndef BINARY_LIFTING_LCA_ASSERT_SVH
`define BINARY_LIFTING_LCA_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BLCA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BLCA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLCA_ASSERT_IMP(label, ante, cons, msg)
`define BLCA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/blca_pkg.sv -----
// types and constants shared by the lowest common ancestor engine
package blca_pkg;

  localparam int ID_W    = 10;
  localparam int DEPTH_W = 10;
  localparam int CMD_W   = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_AW-1:0] REG_NODE_COUNT = 3'd0;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_B_RD1,
    S_B_RD2,
    S_B_WR,
    S_Q_DA,
    S_Q_DB,
    S_Q_DIFF,
    S_Q_LIFT,
    S_Q_LIFT_D,
    S_Q_CMP,
    S_Q_JU,
    S_Q_JV,
    S_Q_JC,
    S_Q_FIN,
    S_Q_FD,
    S_Q_OUT
  } st_t;

endpackage

// ----- hw/rtl/blca_in_if.sv -----
// request channel of the lowest common ancestor engine
interface blca_in_if;
  logic                       valid;
  logic                       ready;
  logic [blca_pkg::CMD_W-1:0]   cmd;
  logic [blca_pkg::ID_W-1:0]    node_a;
  logic [blca_pkg::ID_W-1:0]    node_b;
  logic [blca_pkg::DEPTH_W-1:0] depth;

  modport source (output valid, output cmd, output node_a, output node_b, output depth,
                  input ready);
  modport sink (input valid, input cmd, input node_a, input node_b, input depth,
                output ready);
endinterface

// ----- hw/rtl/blca_out_if.sv -----
// result channel of the lowest common ancestor engine
interface blca_out_if;
  logic                    valid;
  logic                    ready;
  logic [blca_pkg::ID_W-1:0] ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink (input valid, input ancestor, output ready);
endinterface

// ----- hw/rtl/binary_lifting_lca.sv -----
// lowest common ancestor engine, binary lifting over one shared table read port
// load writes a node's parent and depth; build fills levels 1 to LEVELS - 1 of nodes 1 to
// min(node_count, MAX_NODES - 1); query lifts the deeper node, then jumps both nodes down
// the levels, all through the single jump table read port; one request at a time; ready
// is low until the request is finished; synchronous active-low reset, then a clearing
// pass zeroes the jump and depth tables before the first request is taken
`include "binary_lifting_lca_assert.svh"

module binary_lifting_lca #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  blca_in_if.sink                       in_ch,
  blca_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [blca_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [blca_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [blca_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import blca_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int LB = $clog2(LEVELS);
  localparam int AW = NB + LB;
  localparam int JT_DEPTH = MAX_NODES << LB;

  st_t state_r, state_nxt;

  logic [ID_W-1:0]    jt_mem [JT_DEPTH];
  logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

  logic [ID_W-1:0]    jt_rd_r;
  logic [DEPTH_W-1:0] dep_rd_r;
  logic [AW-1:0]      jt_raddr;
  logic [AW-1:0]      jt_waddr;
  logic [ID_W-1:0]    jt_wdata;
  logic               jt_wen;
  logic [NB-1:0]      dep_raddr;
  logic [NB-1:0]      dep_waddr;
  logic [DEPTH_W-1:0] dep_wdata;
  logic               dep_wen;

  logic [ID_W-1:0]    node_count_r;
  logic [AW-1:0]      clr_r;
  logic [NB-1:0]      n_r;
  logic [LB-1:0]      lvl_r;
  logic [NB-1:0]      u_r;
  logic [NB-1:0]      v_r;
  logic [DEPTH_W-1:0] da_r;
  logic [DEPTH_W-1:0] dist_r;
  logic [ID_W-1:0]    ju_r;
  logic [ID_W-1:0]    res_r;
  logic [ID_W-1:0]    anc_r;
  logic               out_valid_r;

  logic               in_fire;
  logic               out_free;
  logic               cfg_wr;
  logic [NB-1:0]      qa;
  logic [NB-1:0]      qb;
  logic [ID_W-1:0]    qb_id;
  logic [NB-1:0]      last_n;
  logic               lvl_top;

  // node ids at or above MAX_NODES fall back to the sentinel
  assign qa    = (32'(in_ch.node_a) < MAX_NODES) ? NB'(in_ch.node_a) : '0;
  assign qb    = (32'(in_ch.node_b) < MAX_NODES) ? NB'(in_ch.node_b) : '0;
  assign qb_id = (32'(in_ch.node_b) < MAX_NODES) ? in_ch.node_b : '0;
  assign last_n = (32'(node_count_r) > MAX_NODES - 1) ? NB'(MAX_NODES - 1)
                                                       : NB'(node_count_r);
  assign lvl_top = (lvl_r == LB'(LEVELS - 1));

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.ancestor = anc_r;
  assign cfg_pready      = 1'b1;
  assign cfg_prdata      = (cfg_paddr[2] == REG_NODE_COUNT[2])
                           ? {{(CFG_DW - ID_W){1'b0}}, node_count_r} : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (&clr_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            CMD_BUILD: if (last_n != '0) state_nxt = S_B_RD1;
            CMD_QUERY: state_nxt = S_Q_DA;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_B_RD1: state_nxt = S_B_RD2;
      S_B_RD2: state_nxt = S_B_WR;
      S_B_WR: begin
        if (n_r == last_n && lvl_top) state_nxt = S_IDLE;
        else                          state_nxt = S_B_RD1;
      end
      S_Q_DA:   state_nxt = S_Q_DB;
      S_Q_DB:   state_nxt = S_Q_DIFF;
      S_Q_DIFF: state_nxt = S_Q_LIFT;
      S_Q_LIFT: begin
        if (dist_r[0])    state_nxt = S_Q_LIFT_D;
        else if (lvl_top) state_nxt = S_Q_CMP;
      end
      S_Q_LIFT_D: state_nxt = lvl_top ? S_Q_CMP : S_Q_LIFT;
      S_Q_CMP:    state_nxt = (u_r == v_r) ? S_Q_OUT : S_Q_JU;
      S_Q_JU:     state_nxt = S_Q_JV;
      S_Q_JV:     state_nxt = S_Q_JC;
      S_Q_JC:     state_nxt = (lvl_r == '0) ? S_Q_FIN : S_Q_JU;
      S_Q_FIN:    state_nxt = S_Q_FD;
      S_Q_FD:     state_nxt = S_Q_OUT;
      S_Q_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    jt_raddr  = {v_r, lvl_r};
    jt_waddr  = {n_r, lvl_r};
    jt_wdata  = jt_rd_r;
    jt_wen    = 1'b0;
    dep_raddr = u_r;
    dep_waddr = qa;
    dep_wdata = in_ch.depth;
    dep_wen   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        jt_waddr  = clr_r;
        jt_wdata  = '0;
        jt_wen    = 1'b1;
        dep_waddr = clr_r[AW-1:LB];
        dep_wdata = '0;
        dep_wen   = 1'b1;
      end
      S_IDLE: begin
        jt_waddr = {qa, LB'(0)};
        jt_wdata = qb_id;
        jt_wen   = in_fire && (in_ch.cmd == CMD_LOAD) && (qa != '0);
        dep_wen  = jt_wen;
      end
      S_B_RD1: jt_raddr = {n_r, lvl_r - LB'(1)};
      S_B_RD2: jt_raddr = {NB'(jt_rd_r), lvl_r - LB'(1)};
      S_B_WR:  jt_wen = 1'b1;
      S_Q_DA:  dep_raddr = u_r;
      S_Q_DB:  dep_raddr = v_r;
      S_Q_LIFT: jt_raddr = {v_r, lvl_r};
      S_Q_JU:  jt_raddr = {u_r, lvl_r};
      S_Q_JV:  jt_raddr = {v_r, lvl_r};
      S_Q_FIN: jt_raddr = {u_r, LB'(0)};
      default: begin
        jt_wen  = 1'b0;
        dep_wen = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (jt_wen) jt_mem[jt_waddr] <= jt_wdata;
    jt_rd_r <= jt_mem[jt_raddr];
  end

  always_ff @(posedge clk) begin
    if (dep_wen) dep_mem[dep_waddr] <= dep_wdata;
    dep_rd_r <= dep_mem[dep_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      node_count_r <= ID_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (cfg_wr && cfg_paddr[2] == REG_NODE_COUNT[2]) node_count_r <= cfg_pwdata[ID_W-1:0];
      if (state_r == S_Q_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)              out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r   <= NB'(1);
        lvl_r <= LB'(1);
        u_r   <= qa;
        v_r   <= qb;
      end
      S_B_WR: begin
        if (n_r == last_n) begin
          n_r   <= NB'(1);
          lvl_r <= lvl_r + LB'(1);
        end else begin
          n_r <= n_r + NB'(1);
        end
      end
      S_Q_DB: da_r <= dep_rd_r;
      S_Q_DIFF: begin
        lvl_r <= '0;
        if (da_r > dep_rd_r) begin
          u_r    <= v_r;
          v_r    <= u_r;
          dist_r <= da_r - dep_rd_r;
        end else begin
          dist_r <= dep_rd_r - da_r;
        end
      end
      S_Q_LIFT: begin
        if (!dist_r[0]) begin
          dist_r <= dist_r >> 1;
          if (!lvl_top) lvl_r <= lvl_r + LB'(1);
        end
      end
      S_Q_LIFT_D: begin
        v_r    <= NB'(jt_rd_r);
        dist_r <= dist_r >> 1;
        if (!lvl_top) lvl_r <= lvl_r + LB'(1);
      end
      S_Q_CMP: begin
        res_r <= ID_W'(v_r);
        lvl_r <= LB'(LEVELS - 1);
      end
      S_Q_JV: ju_r <= jt_rd_r;
      S_Q_JC: begin
        if (ju_r != jt_rd_r) begin
          u_r <= NB'(ju_r);
          v_r <= NB'(jt_rd_r);
        end
        if (lvl_r != '0) lvl_r <= lvl_r - LB'(1);
      end
      S_Q_FD: res_r <= jt_rd_r;
      S_Q_OUT: begin
        if (out_free) anc_r <= res_r;
      end
      default: begin
        da_r <= da_r;
      end
    endcase
  end

  `BLCA_ASSERT_NXT(a_query_start, in_fire && in_ch.cmd == CMD_QUERY, state_r == S_Q_DA, "query did not start")
  `BLCA_ASSERT_IMP(a_clear_zero, state_r == S_CLEAR, jt_wen && jt_wdata == '0 && dep_wen, "clearing pass not writing zero")
  `BLCA_ASSERT_NXT(a_result_out, state_r == S_Q_OUT && out_free, out_valid_r && anc_r == $past(res_r), "result not presented")
  `BLCA_ASSERT_IMP(a_lvl_range, state_r != S_CLEAR && state_r != S_IDLE, 32'(lvl_r) < LEVELS, "level counter out of range")

endmodule
